// ----- sv/set_assoc_cache_tag_lru_defines.svh -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_defines
// assertion macros shared by the checker of the cache tag engine
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LRU_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LRU_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SACL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sacl same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sacl next-cycle check failed");

`endif

// ----- sv/sacl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// types, codes and defaults of the set-associative cache tag engine
// ----------------------------------------------------------------------------
package sacl_pkg;

	// default geometry
	localparam int WAYS_DEF     = 4;
	localparam int SETS_DEF     = 256;
	localparam int TAG_BITS_DEF = 48;

	// fixed field widths of the channels
	localparam int SET_IDX_W  = 8;
	localparam int LINE_TAG_W = 48;
	localparam int WAY_OUT_W  = 2;
	localparam int SET_IDX_N  = 2 ** SET_IDX_W;

	localparam logic MODE_ACCESS = 1'b0;
	localparam logic MODE_INVAL  = 1'b1;

	typedef enum logic [1:0] {
		OUT_HIT     = 2'd0,
		OUT_FILL    = 2'd1,
		OUT_REPLACE = 2'd2,
		OUT_INVAL   = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_INV_RESP
	} state_t;

	typedef struct packed {
		logic                  mode;
		logic [SET_IDX_W-1:0]  set_index;
		logic [LINE_TAG_W-1:0] line_tag;
		logic                  is_write;
	} req_t;

	typedef struct packed {
		outcome_t              outcome;
		logic [WAY_OUT_W-1:0]  way;
		logic                  writeback;
		logic [LINE_TAG_W-1:0] victim_tag;
	} rsp_t;

endpackage
`default_nettype wire

// ----- sv/sacl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                           rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/sacl_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_lookup
// way selection and true lru update for one set row
// ----------------------------------------------------------------------------
module sacl_lookup #(
	parameter int WAYS     = sacl_pkg::WAYS_DEF,
	parameter int TAG_BITS = sacl_pkg::TAG_BITS_DEF
) (
	input  wire logic [2*WAYS+WAYS*$clog2(WAYS)-1:0] row,
	input  wire logic [WAYS*TAG_BITS-1:0]            tags,
	input  wire logic [TAG_BITS-1:0]                 tag,
	input  wire logic                                is_write,
	output      logic [2*WAYS+WAYS*$clog2(WAYS)-1:0] new_row,
	output      logic [WAYS*TAG_BITS-1:0]            new_tags,
	output      logic                                tag_we,
	output      sacl_pkg::rsp_t                      rsp
);

	localparam int WAY_W = $clog2(WAYS);
	localparam int LRU_LO = 2 * WAYS;

	logic [WAYS-1:0]     valid;
	logic [WAYS-1:0]     dirty;
	logic [WAY_W-1:0]    order [WAYS];
	logic [TAG_BITS-1:0] tag_arr [WAYS];
	logic [WAYS-1:0]     hit_vec;

	always_comb begin
		valid = row[WAYS-1:0];
		dirty = row[2*WAYS-1:WAYS];
		for (int p = 0; p < WAYS; p++) begin
			order[p]   = row[LRU_LO + p*WAY_W +: WAY_W];
			tag_arr[p] = tags[p*TAG_BITS +: TAG_BITS];
			hit_vec[p] = valid[p] && (tag_arr[p] == tag);
		end
	end

	logic             hit;
	logic             free;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] victim;
	logic [WAY_W-1:0] way_sel;
	logic [WAY_W-1:0] pos;
	logic [WAYS-1:0]  sel_mask;
	logic [WAYS-1:0]  nvalid;
	logic [WAYS-1:0]  ndirty;

	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_way  = '0;
		free_way = '0;
		// downward scan leaves the lowest-numbered way
		for (int w = WAYS-1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid[w]) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		victim = (order[WAYS-1] < WAYS) ? order[WAYS-1] : '0;

		if (hit) begin
			way_sel = hit_way;
		end else if (free) begin
			way_sel = free_way;
		end else begin
			way_sel = victim;
		end

		pos = WAY_W'(WAYS - 1);
		if (hit || free) begin
			for (int p = 0; p < WAYS; p++) begin
				if (order[p] == way_sel) begin
					pos = WAY_W'(p);
				end
			end
		end

		sel_mask = WAYS'(1) << way_sel;
		if (hit) begin
			nvalid = valid;
			ndirty = is_write ? (dirty | sel_mask) : dirty;
		end else begin
			nvalid = valid | sel_mask;
			ndirty = is_write ? (dirty | sel_mask) : (dirty & ~sel_mask);
		end

		new_row[WAYS-1:0]      = nvalid;
		new_row[2*WAYS-1:WAYS] = ndirty;
		// move the chosen way to the front, entries above it slide down
		for (int p = 0; p < WAYS; p++) begin
			if (p == 0) begin
				new_row[LRU_LO +: WAY_W] = way_sel;
			end else if (pos >= WAY_W'(p)) begin
				new_row[LRU_LO + p*WAY_W +: WAY_W] = order[p-1];
			end else begin
				new_row[LRU_LO + p*WAY_W +: WAY_W] = order[p];
			end
		end

		for (int w = 0; w < WAYS; w++) begin
			new_tags[w*TAG_BITS +: TAG_BITS] = (way_sel == WAY_W'(w)) ? tag : tag_arr[w];
		end
		tag_we = !hit;

		rsp.way = sacl_pkg::WAY_OUT_W'(way_sel);
		if (hit) begin
			rsp.outcome    = sacl_pkg::OUT_HIT;
			rsp.writeback  = 1'b0;
			rsp.victim_tag = '0;
		end else if (free) begin
			rsp.outcome    = sacl_pkg::OUT_FILL;
			rsp.writeback  = 1'b0;
			rsp.victim_tag = '0;
		end else begin
			rsp.outcome    = sacl_pkg::OUT_REPLACE;
			rsp.writeback  = dirty[victim];
			rsp.victim_tag = sacl_pkg::LINE_TAG_W'(tag_arr[victim]);
		end
	end

endmodule
`default_nettype wire

// ----- sv/set_assoc_cache_tag_lru.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru
// tag lookup and true lru replacement engine of a set-associative cache
// ----------------------------------------------------------------------------
// Requests come in on req_valid/req_ready/req_data, one result per request
// leaves on rsp_valid/rsp_ready/rsp_data.
// An access transfer is taken in the idle state and the tag and state rams are
// read; the lookup state then compares tags, picks the way, writes the set back
// and loads the result register, which drives rsp_valid. A new access is taken
// only once the set is written back and the block is idle again: the read and
// the write-back of the set row each occupy the ram ports.
// Invalidate-all sweeps the state ram with a pipelined read and write of each
// row, clearing the valid bits and keeping the lru order; the result is then
// loaded and the block returns to idle.
// After reset an init pass writes every row (no valid lines, identity lru
// order); req_ready stays low during it.
// A result waits in the output register while rsp_ready is low; the next
// request is still taken, and its write-back waits until the register frees.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru #(
	parameter int WAYS     = sacl_pkg::WAYS_DEF,
	parameter int SETS     = sacl_pkg::SETS_DEF,
	parameter int TAG_BITS = sacl_pkg::TAG_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output      logic           req_ready,
	input  wire sacl_pkg::req_t req_data,
	output      logic           rsp_valid,
	input  wire logic           rsp_ready,
	output      sacl_pkg::rsp_t rsp_data
);

	localparam int WAY_W  = $clog2(WAYS);
	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int CNT_W  = $clog2(SETS + 1);
	localparam int ROW_W  = 2*WAYS + WAYS*WAY_W;
	localparam int TROW_W = WAYS * TAG_BITS;

	// set index wrap table, one entry per input index value
	logic [SET_W-1:0] wrap_tbl [sacl_pkg::SET_IDX_N];
	for (genvar i = 0; i < sacl_pkg::SET_IDX_N; i++) begin : g_wrap
		assign wrap_tbl[i] = SET_W'(i % SETS);
	end

	// row written by the init pass
	logic [ROW_W-1:0] init_row;
	assign init_row[2*WAYS-1:0] = '0;
	for (genvar p = 0; p < WAYS; p++) begin : g_init
		assign init_row[2*WAYS + p*WAY_W +: WAY_W] = WAY_W'(p);
	end

	sacl_pkg::state_t state_q, state_next;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_prev;
	logic [SET_W-1:0] set_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic             write_s1;
	logic             rsp_valid_q;
	sacl_pkg::rsp_t   rsp_q;
	logic             rsp_free;
	logic             req_fire;

	logic             ram_re;
	logic [SET_W-1:0] ram_raddr;
	logic             st_we;
	logic [SET_W-1:0] st_waddr;
	logic [ROW_W-1:0] st_wdata;
	logic [ROW_W-1:0] st_rdata;
	logic             tg_we;
	logic [TROW_W-1:0] tg_rdata;

	logic [ROW_W-1:0]  lk_row;
	logic [TROW_W-1:0] lk_tags;
	logic              lk_tag_we;
	sacl_pkg::rsp_t    lk_rsp;

	logic              rsp_load;
	sacl_pkg::rsp_t    rsp_next;

	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign req_fire = req_valid && req_ready;
	assign cnt_prev = cnt_q - 1'b1;

	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_state_ram (
		.clk     (clk),
		.we      (st_we),
		.waddr   (st_waddr),
		.wdata   (st_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (st_rdata)
	);

	sacl_ram #(
		.WIDTH (TROW_W),
		.DEPTH (SETS)
	) u_tag_ram (
		.clk     (clk),
		.we      (tg_we),
		.waddr   (set_s1),
		.wdata   (lk_tags),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (tg_rdata)
	);

	sacl_lookup #(
		.WAYS     (WAYS),
		.TAG_BITS (TAG_BITS)
	) u_lookup (
		.row      (st_rdata),
		.tags     (tg_rdata),
		.tag      (tag_s1),
		.is_write (write_s1),
		.new_row  (lk_row),
		.new_tags (lk_tags),
		.tag_we   (lk_tag_we),
		.rsp      (lk_rsp)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			sacl_pkg::ST_INIT: begin
				if (cnt_q == CNT_W'(SETS - 1)) begin
					state_next = sacl_pkg::ST_IDLE;
				end
			end
			sacl_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_next = (req_data.mode == sacl_pkg::MODE_INVAL) ?
						sacl_pkg::ST_SWEEP : sacl_pkg::ST_LOOKUP;
				end
			end
			sacl_pkg::ST_LOOKUP: begin
				if (rsp_free) begin
					state_next = sacl_pkg::ST_IDLE;
				end
			end
			sacl_pkg::ST_SWEEP: begin
				if (cnt_q == CNT_W'(SETS)) begin
					state_next = sacl_pkg::ST_INV_RESP;
				end
			end
			sacl_pkg::ST_INV_RESP: begin
				if (rsp_free) begin
					state_next = sacl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = sacl_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = wrap_tbl[req_data.set_index];
		st_we     = 1'b0;
		st_waddr  = set_s1;
		st_wdata  = lk_row;
		tg_we     = 1'b0;
		rsp_load  = 1'b0;
		rsp_next  = lk_rsp;
		case (state_q)
			sacl_pkg::ST_INIT: begin
				st_we    = 1'b1;
				st_waddr = cnt_q[SET_W-1:0];
				st_wdata = init_row;
			end
			sacl_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				ram_re    = req_valid && (req_data.mode == sacl_pkg::MODE_ACCESS);
			end
			sacl_pkg::ST_LOOKUP: begin
				st_we    = rsp_free;
				tg_we    = rsp_free && lk_tag_we;
				rsp_load = rsp_free;
			end
			sacl_pkg::ST_SWEEP: begin
				// read row cnt while the row read last cycle goes back cleared
				ram_re    = (cnt_q < CNT_W'(SETS));
				ram_raddr = cnt_q[SET_W-1:0];
				st_we     = (cnt_q != '0);
				st_waddr  = cnt_prev[SET_W-1:0];
				st_wdata  = {st_rdata[ROW_W-1:WAYS], WAYS'(0)};
			end
			sacl_pkg::ST_INV_RESP: begin
				rsp_load            = rsp_free;
				rsp_next.outcome    = sacl_pkg::OUT_INVAL;
				rsp_next.way        = '0;
				rsp_next.writeback  = 1'b0;
				rsp_next.victim_tag = '0;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacl_pkg::ST_INIT;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_next != state_q) begin
				cnt_q <= '0;
			end else if (state_q == sacl_pkg::ST_INIT || state_q == sacl_pkg::ST_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			set_s1   <= wrap_tbl[req_data.set_index];
			tag_s1   <= TAG_BITS'(req_data.line_tag);
			write_s1 <= req_data.is_write;
		end
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
`default_nettype wire

// ----- sv/sacl_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_checker
// port-level checks of the cache tag engine, bound to the top level
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_lru_defines.svh"

module sacl_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire sacl_pkg::rsp_t rsp_data
);

	// a stalled result holds
	`SACL_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// one request at a time: no transfer right after a transfer
	`SACL_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)

	// only a replacement reports a victim
	`SACL_ASSERT_IMP(a_no_victim, clk, arst_n, rsp_valid && (rsp_data.outcome == sacl_pkg::OUT_HIT || rsp_data.outcome == sacl_pkg::OUT_FILL), !rsp_data.writeback && rsp_data.victim_tag == '0)

	// invalidate result carries no way and no victim
	`SACL_ASSERT_IMP(a_inval_clean, clk, arst_n, rsp_valid && rsp_data.outcome == sacl_pkg::OUT_INVAL, rsp_data.way == '0 && !rsp_data.writeback && rsp_data.victim_tag == '0)

endmodule

bind set_assoc_cache_tag_lru sacl_checker u_sacl_checker (.*);
`default_nettype wire

// ----- verif/set_assoc_cache_tag_lru_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_tb
// self-checking bench for the cache tag lookup and true lru replacement engine
// ----------------------------------------------------------------------------
// A tracker class mirrors the valid, dirty, tag and lru state of every set
// and predicts the result of each accepted request transfer; every response
// transfer is compared field by field against the oldest prediction.
// Directed requests walk fills, hits, dirty and clean evictions and
// invalidate-all; random requests concentrate on a few sets and a small tag
// pool so that hits and evictions are frequent, under four idling phases,
// a long response hold-off and drain pauses between phases.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_tb;
	import sacl_pkg::*;

	localparam int N_WAYS        = WAYS_DEF;
	localparam int N_SETS        = SETS_DEF;
	localparam int ITEMS_PHASE   = 240;
	localparam int HOLD_OFF      = 200;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int REPORT_MAX    = 10;

	class lru_tag_tracker;
		bit           line_valid [N_SETS][N_WAYS];
		bit           line_dirty [N_SETS][N_WAYS];
		logic [47:0]  line_tag_q [N_SETS][N_WAYS];
		logic [1:0]   lru_rank   [N_SETS][N_WAYS];
		rsp_t         expected_rsp_q[$];
		int           mismatches;
		int           checked;
		int           n_hit, n_fill, n_repl, n_wb, n_inval;

		function void clear_state();
			for (int s = 0; s < N_SETS; s++) begin
				for (int w = 0; w < N_WAYS; w++) begin
					line_valid[s][w] = 1'b0;
					line_dirty[s][w] = 1'b0;
					line_tag_q[s][w] = '0;
					lru_rank[s][w]   = 2'(w);
				end
			end
			expected_rsp_q.delete();
			mismatches = 0;
			checked    = 0;
			n_hit = 0; n_fill = 0; n_repl = 0; n_wb = 0; n_inval = 0;
		endfunction

		// rank 0 is most recently used, rank N_WAYS-1 the victim
		function void move_to_front(int s, int pos);
			logic [1:0] w;
			w = lru_rank[s][pos];
			for (int p = pos; p > 0; p--) lru_rank[s][p] = lru_rank[s][p-1];
			lru_rank[s][0] = w;
		endfunction

		function void touch_way(int s, int w);
			for (int p = 0; p < N_WAYS; p++) begin
				if (lru_rank[s][p] == 2'(w)) begin
					move_to_front(s, p);
					return;
				end
			end
		endfunction

		function rsp_t predict_access(req_t r);
			rsp_t e;
			int   s;
			int   hit_way;
			int   free_way;
			int   w;
			e = '0;
			if (r.mode == MODE_INVAL) begin
				for (int i = 0; i < N_SETS; i++)
					for (int j = 0; j < N_WAYS; j++) line_valid[i][j] = 1'b0;
				e.outcome = OUT_INVAL;
				return e;
			end
			s        = int'(r.set_index) % N_SETS;
			hit_way  = -1;
			free_way = -1;
			for (int j = 0; j < N_WAYS; j++)
				if (hit_way < 0 && line_valid[s][j] && line_tag_q[s][j] == r.line_tag)
					hit_way = j;
			if (hit_way >= 0) begin
				e.outcome = OUT_HIT;
				e.way     = 2'(hit_way);
				if (r.is_write) line_dirty[s][hit_way] = 1'b1;
				touch_way(s, hit_way);
				return e;
			end
			for (int j = 0; j < N_WAYS; j++)
				if (free_way < 0 && !line_valid[s][j]) free_way = j;
			if (free_way >= 0) begin
				e.outcome = OUT_FILL;
				w = free_way;
				touch_way(s, w);
			end else begin
				e.outcome    = OUT_REPLACE;
				w            = int'(lru_rank[s][N_WAYS-1]);
				e.writeback  = line_dirty[s][w];
				e.victim_tag = line_tag_q[s][w];
				move_to_front(s, N_WAYS - 1);
			end
			e.way            = 2'(w);
			line_valid[s][w] = 1'b1;
			line_tag_q[s][w] = r.line_tag;
			line_dirty[s][w] = r.is_write;
			return e;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			e = predict_access(r);
			case (e.outcome)
				OUT_HIT:     n_hit++;
				OUT_FILL:    n_fill++;
				OUT_REPLACE: begin
					n_repl++;
					if (e.writeback) n_wb++;
				end
				default:     n_inval++;
			endcase
			expected_rsp_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			checked++;
			if (expected_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected response %0d: outcome %0d way %0d wb %0b tag %h",
						checked, got.outcome, got.way, got.writeback, got.victim_tag);
				return;
			end
			e = expected_rsp_q.pop_front();
			if (got.outcome !== e.outcome || got.way !== e.way ||
			    got.writeback !== e.writeback || got.victim_tag !== e.victim_tag) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch on response %0d: exp outcome %0d way %0d wb %0b tag %h, got outcome %0d way %0d wb %0b tag %h",
						checked, e.outcome, e.way, e.writeback, e.victim_tag,
						got.outcome, got.way, got.writeback, got.victim_tag);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	lru_tag_tracker tracker;
	int             send_idle_pct;
	int             recv_stall_pct;
	int             hold_off_req;
	logic [7:0]     hot_sets [3];
	logic [47:0]    tag_pool [6];

	set_assoc_cache_tag_lru u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	// both transfers are seen at the edge with the values that the block samples
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) tracker.note_request(req_data);
			if (rsp_valid && rsp_ready) tracker.check_response(rsp_data);
		end
	end

	// response side: random stalls, plus a counted hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req > 0) begin
				hold_left    = hold_off_req;
				hold_off_req = 0;
			end
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic req_t mk_req(logic m, logic [7:0] s, logic [47:0] t, logic wr);
		req_t r;
		r.mode      = m;
		r.set_index = s;
		r.line_tag  = t;
		r.is_write  = wr;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.mode      = ($urandom_range(0, 99) < 2) ? MODE_INVAL : MODE_ACCESS;
		r.set_index = ($urandom_range(0, 99) < 75) ? hot_sets[$urandom_range(0, 2)]
		                                           : 8'($urandom);
		r.line_tag  = ($urandom_range(0, 99) < 80) ? tag_pool[$urandom_range(0, 5)]
		                                           : {16'($urandom), 32'($urandom)};
		r.is_write  = 1'($urandom);
		return r;
	endfunction

	// six tags over four ways keeps evictions frequent
	task automatic reshuffle_pools();
		foreach (hot_sets[i]) hot_sets[i] = 8'($urandom);
		foreach (tag_pool[i]) tag_pool[i] = {16'($urandom), 32'($urandom)};
	endtask

	task automatic send_req(input req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	// one edge first so that the transfer just taken is already noted
	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_rsp_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [47:0] tag_a, tag_b, tag_c, tag_d, tag_e, tag_f;
		req_t        directed_q[$];
		int          waited;
		int          leftover;

		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req_data       = '0;
		rsp_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_req   = 0;
		tracker        = new;
		tracker.clear_state();
		reshuffle_pools();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		tag_a = 48'h0000_0000_0000;
		tag_b = 48'hFFFF_FFFF_FFFF;
		tag_c = 48'h5555_AAAA_0F0F;
		tag_d = 48'hA5A5_1234_C3C3;
		tag_e = 48'h0000_0000_0001;
		tag_f = 48'h8000_0000_0000;

		// fill a set, hit it, evict dirty and clean lines, then invalidate
		// and refill so that old dirty bits and the kept lru order matter
		directed_q.push_back(mk_req(MODE_INVAL,  8'd0,   tag_a, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_a, 1'b1));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_b, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_c, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_d, 1'b1));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_c, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_b, 1'b1));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_e, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_f, 1'b1));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_c, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_a, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd255, tag_b, 1'b1));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd255, tag_b, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd128, tag_e, 1'b0));
		directed_q.push_back(mk_req(MODE_INVAL,  8'd255, tag_b, 1'b1));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_c, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_c, 1'b1));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd255, tag_b, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_a, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_b, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_d, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_e, 1'b0));
		directed_q.push_back(mk_req(MODE_ACCESS, 8'd0,   tag_f, 1'b0));
		directed_q.push_back(mk_req(MODE_INVAL,  8'd0,   tag_a, 1'b0));
		directed_q.push_back(mk_req(MODE_INVAL,  8'd0,   tag_a, 1'b0));
		foreach (directed_q[i]) send_req(directed_q[i]);
		wait_drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			reshuffle_pools();
			// long response hold-off while requests keep coming: input backs up
			if (phase == 0) hold_off_req = HOLD_OFF;
			repeat (ITEMS_PHASE) send_req(random_req());
			wait_drain();
		end

		req_valid <= 1'b0;
		waited = 0;
		while (tracker.expected_rsp_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (N_SETS + 20) @(posedge clk);

		leftover = tracker.expected_rsp_q.size();
		if (leftover != 0) $display("%0d responses never arrived", leftover);
		$display("ran %0d requests: %0d hits, %0d fills, %0d evictions (%0d dirty)",
			tracker.n_hit + tracker.n_fill + tracker.n_repl + tracker.n_inval,
			tracker.n_hit, tracker.n_fill, tracker.n_repl, tracker.n_wb);
		$display("%0d invalidate-all sweeps, %0d responses checked, %0d mismatches",
			tracker.n_inval, tracker.checked, tracker.mismatches);
		if (tracker.mismatches == 0 && leftover == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/sacl_pkg.sv
sv/sacl_ram.sv
sv/sacl_lookup.sv
sv/set_assoc_cache_tag_lru.sv
sv/sacl_checker.sv
verif/set_assoc_cache_tag_lru_tb.sv
